>>> hdl/dtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

	localparam int ID_W     = 4;
	localparam int TIME_W   = 64;
	localparam int RELOAD_W = 16;

	localparam logic [RELOAD_W-1:0] RELOAD_MIN = 16'd2;
	localparam logic [RELOAD_W-1:0] RELOAD_MAX = 16'd65534;

	localparam logic CMD_ARM     = 1'b0;
	localparam logic CMD_SERVICE = 1'b1;

	localparam logic KIND_FIRE   = 1'b0;
	localparam logic KIND_RELOAD = 1'b1;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_REMOVE,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] dl;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   key;
	} cell_ctrl_t;

	function automatic logic [RELOAD_W-1:0] reload_for(input logic [TIME_W-1:0] dl,
		input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] diff;
		logic [RELOAD_W-1:0] r;
		diff = dl - now;
		if (dl <= now) begin
			r = RELOAD_MIN;
		end else if (diff < TIME_W'(RELOAD_MIN)) begin
			r = RELOAD_MIN;
		end else if (diff > TIME_W'(RELOAD_MAX)) begin
			r = RELOAD_MAX;
		end else begin
			r = diff[RELOAD_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/dtq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dtq_cell #(
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  wire logic               clk,
	input  wire dtq_pkg::cell_ctrl_t ctrl,
	input  wire logic [CW-1:0]      count,
	input  wire dtq_pkg::entry_t    prev_entry,
	input  wire logic               prev_greater,
	input  wire dtq_pkg::entry_t    next_entry,
	input  wire logic               hit_in,
	output dtq_pkg::entry_t         entry,
	output logic                    greater,
	output logic                    hit_out
);

	dtq_pkg::entry_t entry_q;
	logic            valid;
	logic            match;

	// occupancy follows from the queue fill count
	assign valid   = CW'(IDX) < count;
	assign match   = valid && (entry_q.id == ctrl.key.id);
	assign hit_out = hit_in | match;
	assign greater = !valid || (entry_q.dl > ctrl.key.dl);
	assign entry   = entry_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			dtq_pkg::CELL_HOLD: begin
			end
			dtq_pkg::CELL_REMOVE: begin
				// close the gap left by the removed timer
				if (hit_out) begin
					entry_q <= next_entry;
				end
			end
			dtq_pkg::CELL_INSERT: begin
				if (prev_greater) begin
					entry_q <= prev_entry;
				end else if (greater) begin
					entry_q <= ctrl.key;
				end
			end
			dtq_pkg::CELL_SHIFT: begin
				entry_q <= next_entry;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/deadline_timer_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted deadline timer queue. Up to NUM_TIMERS timers sit in a row of cells
// ordered by 64-bit deadline; each cell holds one timer and trades entries
// with its neighbors to insert, remove or pop.
// Input requests (s_axis): tuser = cmd (arm or service). An arm request
// requeues timer_id at deadline and gives one reload result if the timer
// lands at the head. A service request pops every due timer as a fire result
// in deadline order, then gives a reload result for the new head, if any.
// Results (m_axis): tuser = event_kind, tlast marks the final result of a
// request; a request may give no result at all.
// Sequence: an arm request runs a remove pass (ST_REMOVE), an insert pass
// (ST_INSERT) and a reload step (ST_RELOAD) when the timer lands at the head,
// then returns to idle; a service request pops the head cell one entry per
// cycle while the output register is free, then gives the head reload.
// One request is processed at a time; the input is ready only while idle.
// A stalled receiver holds the output register and freezes the reload and
// service steps until the result is taken.
// Reset empties the queue at once (fill count cleared); no clearing pass.
module deadline_timer_queue_unit #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [3:0] timer_id, [67:4] deadline, [131:68] now_time, [135:132] zero
	input  wire logic [135:0] s_axis_tdata,
	// [0] cmd
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [3:0] fired_id, [67:4] expire_time, [83:68] reload_value, [87:84] zero
	output logic [87:0]       m_axis_tdata,
	// [0] event_kind
	output logic              m_axis_tuser,
	output logic              m_axis_tlast
);

	localparam int CW = $clog2(NUM_TIMERS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_RELOAD,
		ST_SERVICE
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   count_q;
	logic [dtq_pkg::ID_W-1:0]        id_q;
	logic [dtq_pkg::TIME_W-1:0]      dl_q;
	logic [dtq_pkg::TIME_W-1:0]      now_q;

	logic                            out_valid_q;
	logic                            out_kind_q;
	logic                            out_last_q;
	logic [dtq_pkg::ID_W-1:0]        out_id_q;
	logic [dtq_pkg::TIME_W-1:0]      out_exp_q;
	logic [dtq_pkg::RELOAD_W-1:0]    out_reload_q;

	dtq_pkg::cell_ctrl_t             ctrl;
	dtq_pkg::entry_t                 entries [NUM_TIMERS];
	logic                            greater [NUM_TIMERS];
	logic                            hit     [NUM_TIMERS+1];

	logic                            out_free;
	logic                            q_full;
	logic                            q_empty;
	logic                            head_due;
	logic [dtq_pkg::TIME_W-1:0]      reload_src;
	logic [dtq_pkg::RELOAD_W-1:0]    reload_val;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0000, out_reload_q, out_exp_q, out_id_q};

	assign out_free   = !out_valid_q || m_axis_tready;
	assign q_full     = (count_q == CW'(NUM_TIMERS));
	assign q_empty    = (count_q == '0);
	assign head_due   = !q_empty && (entries[0].dl <= now_q);
	assign reload_src = (state_q == ST_SERVICE) ? entries[0].dl : dl_q;
	assign reload_val = dtq_pkg::reload_for(reload_src, now_q);

	always_comb begin
		ctrl.key.id = id_q;
		ctrl.key.dl = dl_q;
		ctrl.op     = dtq_pkg::CELL_HOLD;
		unique case (state_q)
			ST_REMOVE:  ctrl.op = dtq_pkg::CELL_REMOVE;
			ST_INSERT:  ctrl.op = q_full ? dtq_pkg::CELL_HOLD : dtq_pkg::CELL_INSERT;
			ST_SERVICE: begin
				// pop the head once its fire result is loaded
				if (out_free && head_due) begin
					ctrl.op = dtq_pkg::CELL_SHIFT;
				end
			end
			default:    ctrl.op = dtq_pkg::CELL_HOLD;
		endcase
	end

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		dtq_pkg::entry_t prev_e;
		dtq_pkg::entry_t next_e;
		logic            prev_g;

		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = entries[i-1];
			assign prev_g = greater[i-1];
		end

		if (i == NUM_TIMERS - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = entries[i+1];
		end

		dtq_cell #(
			.CW (CW),
			.IDX(i)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.prev_entry  (prev_e),
			.prev_greater(prev_g),
			.next_entry  (next_e),
			.hit_in      (hit[i]),
			.entry       (entries[i]),
			.greater     (greater[i]),
			.hit_out     (hit[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			id_q         <= '0;
			dl_q         <= '0;
			now_q        <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= dtq_pkg::KIND_FIRE;
			out_last_q   <= 1'b0;
			out_id_q     <= '0;
			out_exp_q    <= '0;
			out_reload_q <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						id_q    <= s_axis_tdata[3:0];
						dl_q    <= s_axis_tdata[67:4];
						now_q   <= s_axis_tdata[131:68];
						state_q <= (s_axis_tuser == dtq_pkg::CMD_SERVICE) ? ST_SERVICE
							: ST_REMOVE;
					end
				end
				ST_REMOVE: begin
					if (hit[NUM_TIMERS]) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					// drop the request when a new timer finds the queue full
					if (q_full) begin
						state_q <= ST_IDLE;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= greater[0] ? ST_RELOAD : ST_IDLE;
					end
				end
				ST_RELOAD: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= dtq_pkg::KIND_RELOAD;
						out_last_q   <= 1'b1;
						out_id_q     <= '0;
						out_exp_q    <= '0;
						out_reload_q <= reload_val;
						state_q      <= ST_IDLE;
					end
				end
				ST_SERVICE: begin
					if (out_free) begin
						priority if (head_due) begin
							out_valid_q  <= 1'b1;
							out_kind_q   <= dtq_pkg::KIND_FIRE;
							// a second entry either fires too or needs a reload
							out_last_q   <= (count_q <= CW'(1));
							out_id_q     <= entries[0].id;
							out_exp_q    <= entries[0].dl;
							out_reload_q <= '0;
							count_q      <= count_q - CW'(1);
						end else if (!q_empty) begin
							out_valid_q  <= 1'b1;
							out_kind_q   <= dtq_pkg::KIND_RELOAD;
							out_last_q   <= 1'b1;
							out_id_q     <= '0;
							out_exp_q    <= '0;
							out_reload_q <= reload_val;
							state_q      <= ST_IDLE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_TIMERS))
		else $error("queue fill count exceeds capacity");

	a_head_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q > CW'(1)) |-> (entries[0].dl <= entries[1].dl))
		else $error("queue head out of deadline order");

	a_reload_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == dtq_pkg::KIND_RELOAD) |->
		(out_last_q && out_reload_q >= dtq_pkg::RELOAD_MIN
		&& out_reload_q <= dtq_pkg::RELOAD_MAX))
		else $error("reload result malformed");

	a_fire_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SERVICE && out_free && head_due) |=>
		(count_q == $past(count_q) - CW'(1)))
		else $error("fired timer not removed from queue");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int ID_W       = dtq_pkg::ID_W;
	localparam int TIME_W     = dtq_pkg::TIME_W;
	localparam int RELOAD_W   = dtq_pkg::RELOAD_W;
	localparam int SLOTS      = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 120;

	typedef struct {
		logic              cmd;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] dl;
		logic [TIME_W-1:0] now;
		bit                drain;
	} timer_request_t;

	typedef struct {
		logic                kind;
		logic [ID_W-1:0]     id;
		logic [TIME_W-1:0]   expire;
		logic [RELOAD_W-1:0] reload;
		logic                last;
	} timer_event_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// [3:0] timer_id, [67:4] deadline, [131:68] now_time, [135:132] zero
	logic [135:0] s_axis_tdata = '0;
	// [0] cmd
	logic         s_axis_tuser = dtq_pkg::CMD_ARM;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// [3:0] fired_id, [67:4] expire_time, [83:68] reload_value, [87:84] zero
	logic [87:0]  m_axis_tdata;
	// [0] event_kind
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	timer_request_t request_backlog[$];
	timer_event_t   pending_events[$];

	// predicted queue contents, in deadline order
	logic [ID_W-1:0]   slot_order[SLOTS];
	logic [TIME_W-1:0] slot_deadline[SLOTS];
	int                slot_fill = 0;

	int             mismatch_count = 0;
	int             idle_cycles = 0;
	int             src_wait = 0;
	int             sink_wait = 0;
	int             requests_seen = 0;
	int             wait_now;
	int             hold_now;
	bit             src_burst = 1'b0;
	bit             sink_burst = 1'b0;
	bit             all_delivered = 1'b0;
	timer_request_t next_req;
	timer_request_t seen_req;
	timer_event_t   want;

	deadline_timer_queue_unit #(
		.NUM_TIMERS(SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #4 clk = ~clk;

	function automatic int draw_wait(input bit steady);
		return steady ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic logic [RELOAD_W-1:0] ticks_to_head(input logic [TIME_W-1:0] dl,
		input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] span;
		span = dl - now;
		if (dl <= now || span < TIME_W'(dtq_pkg::RELOAD_MIN))
			return dtq_pkg::RELOAD_MIN;
		if (span > TIME_W'(dtq_pkg::RELOAD_MAX))
			return dtq_pkg::RELOAD_MAX;
		return span[RELOAD_W-1:0];
	endfunction

	task automatic note_event(input logic kind, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] expire, input logic [RELOAD_W-1:0] reload);
		timer_event_t ev;
		ev.kind   = kind;
		ev.id     = id;
		ev.expire = expire;
		ev.reload = reload;
		ev.last   = 1'b0;
		pending_events.push_back(ev);
	endtask

	task automatic drop_slot(input int pos);
		int i;
		for (i = pos; i < slot_fill - 1; i++) begin
			slot_order[i]    = slot_order[i + 1];
			slot_deadline[i] = slot_deadline[i + 1];
		end
		slot_fill--;
	endtask

	task automatic advance_timer_queue(input timer_request_t r);
		int           i;
		int           hit;
		int           pos;
		int           n_before;
		timer_event_t ev;
		n_before = pending_events.size();
		if (r.cmd == dtq_pkg::CMD_ARM) begin
			hit = -1;
			for (i = 0; i < slot_fill; i++) begin
				if (hit < 0 && slot_order[i] == r.id)
					hit = i;
			end
			// a new timer with every slot in use is dropped
			if (hit < 0 && slot_fill >= SLOTS)
				return;
			if (hit >= 0)
				drop_slot(hit);
			pos = 0;
			while (pos < slot_fill && slot_deadline[pos] <= r.dl)
				pos++;
			for (i = slot_fill; i > pos; i--) begin
				slot_order[i]    = slot_order[i - 1];
				slot_deadline[i] = slot_deadline[i - 1];
			end
			slot_order[pos]    = r.id;
			slot_deadline[pos] = r.dl;
			slot_fill++;
			if (pos == 0)
				note_event(dtq_pkg::KIND_RELOAD, '0, '0, ticks_to_head(r.dl, r.now));
		end else begin
			while (slot_fill > 0 && slot_deadline[0] <= r.now) begin
				note_event(dtq_pkg::KIND_FIRE, slot_order[0], slot_deadline[0], '0);
				drop_slot(0);
			end
			if (slot_fill > 0)
				note_event(dtq_pkg::KIND_RELOAD, '0, '0,
					ticks_to_head(slot_deadline[0], r.now));
		end
		if (pending_events.size() > n_before) begin
			ev = pending_events.pop_back();
			ev.last = 1'b1;
			pending_events.push_back(ev);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
		input logic [TIME_W-1:0] exp_val);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, exp_val);
		mismatch_count++;
	endtask

	task automatic add_request(input logic cmd, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] now, input bit drain);
		timer_request_t r;
		r.cmd   = cmd;
		r.id    = id;
		r.dl    = dl;
		r.now   = now;
		r.drain = drain;
		request_backlog.push_back(r);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= dtq_pkg::CMD_ARM;
			src_wait      <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid && $urandom_range(0, 24) == 0)
				src_burst = !src_burst;
			wait_now = s_axis_tvalid ? draw_wait(src_burst) : src_wait;
			if (wait_now != 0) begin
				src_wait      <= wait_now - 1;
				s_axis_tvalid <= 1'b0;
			end else if (request_backlog.size() != 0 &&
				(!request_backlog[0].drain || (!s_axis_tvalid && all_delivered))) begin
				next_req = request_backlog.pop_front();
				s_axis_tdata  <= {4'b0, next_req.now, next_req.dl, next_req.id};
				s_axis_tuser  <= next_req.cmd;
				s_axis_tvalid <= 1'b1;
				src_wait      <= 0;
			end else begin
				s_axis_tvalid <= 1'b0;
				src_wait      <= 0;
			end
		end
	end

	// result sink; hold off for a long stretch twice while requests keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_wait     <= 0;
			requests_seen <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				requests_seen <= requests_seen + 1;
			if (s_axis_tvalid && s_axis_tready &&
				(requests_seen == 40 || requests_seen == 150)) begin
				sink_wait     <= LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (m_axis_tvalid && m_axis_tready) begin
				if ($urandom_range(0, 24) == 0)
					sink_burst = !sink_burst;
				hold_now = draw_wait(sink_burst);
				sink_wait     <= hold_now;
				m_axis_tready <= (hold_now == 0);
			end else if (sink_wait != 0) begin
				sink_wait     <= sink_wait - 1;
				m_axis_tready <= (sink_wait == 1);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// check results first, then predict from the request taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_events.size() == 0) begin
					report_mismatch("result with nothing pending", m_axis_tdata[63:0], '0);
				end else begin
					want = pending_events.pop_front();
					if (m_axis_tuser !== want.kind)
						report_mismatch("event_kind", TIME_W'(m_axis_tuser), TIME_W'(want.kind));
					if (m_axis_tdata[3:0] !== want.id)
						report_mismatch("fired_id", TIME_W'(m_axis_tdata[3:0]), TIME_W'(want.id));
					if (m_axis_tdata[67:4] !== want.expire)
						report_mismatch("expire_time", m_axis_tdata[67:4], want.expire);
					if (m_axis_tdata[83:68] !== want.reload)
						report_mismatch("reload_value", TIME_W'(m_axis_tdata[83:68]),
							TIME_W'(want.reload));
					if (m_axis_tdata[87:84] !== 4'b0)
						report_mismatch("tdata pad", TIME_W'(m_axis_tdata[87:84]), '0);
					if (m_axis_tlast !== want.last)
						report_mismatch("last", TIME_W'(m_axis_tlast), TIME_W'(want.last));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen_req.cmd   = s_axis_tuser;
				seen_req.id    = s_axis_tdata[3:0];
				seen_req.dl    = s_axis_tdata[67:4];
				seen_req.now   = s_axis_tdata[131:68];
				seen_req.drain = 1'b0;
				advance_timer_queue(seen_req);
			end
			all_delivered <= (pending_events.size() == 0);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int                i;
		int                pick;
		logic [TIME_W-1:0] clock_now;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] dl;

		// directed part
		add_request(dtq_pkg::CMD_SERVICE, 0, 0, 0, 1'b0);     // empty queue, nothing due
		add_request(dtq_pkg::CMD_ARM, 0, 100, 0, 1'b0);
		add_request(dtq_pkg::CMD_ARM, 1, 100, 0, 1'b0);       // equal deadline queues behind
		add_request(dtq_pkg::CMD_ARM, 2, 40, 39, 1'b0);       // one tick ahead: clamp up
		add_request(dtq_pkg::CMD_ARM, 3, 10, 20, 1'b0);       // already past at head
		add_request(dtq_pkg::CMD_ARM, 4, 200000, 0, 1'b0);
		add_request(dtq_pkg::CMD_ARM, 3, 300, 20, 1'b0);      // rearm moves the head back
		add_request(dtq_pkg::CMD_SERVICE, 15, '1, 39, 1'b0);  // nothing due, head reload only
		add_request(dtq_pkg::CMD_SERVICE, 0, 0, 100, 1'b0);   // fire three incl. a tie
		add_request(dtq_pkg::CMD_ARM, 5, '1, 0, 1'b0);
		add_request(dtq_pkg::CMD_SERVICE, 0, 0, 300, 1'b0);   // reload clamps high
		add_request(dtq_pkg::CMD_ARM, 6, 400 + 65534, 400, 1'b0);
		add_request(dtq_pkg::CMD_ARM, 7, 402, 400, 1'b0);
		add_request(dtq_pkg::CMD_ARM, 8, 403, 400, 1'b0);
		for (i = 0; i < SLOTS; i++) begin
			if (i < 4 || i > 8)
				add_request(dtq_pkg::CMD_ARM, ID_W'(i), TIME_W'(1000 + (i / 2) * 10),
					400, 1'b0);
		end
		add_request(dtq_pkg::CMD_ARM, 5, 0, 0, 1'b0);         // rearm with every slot in use
		add_request(dtq_pkg::CMD_SERVICE, 0, 0, '1, 1'b0);    // everything fires
		add_request(dtq_pkg::CMD_ARM, 10, 0, '1, 1'b0);
		add_request(dtq_pkg::CMD_SERVICE, 0, 0, 0, 1'b0);

		// random part: time mostly moves forward, deadlines cluster ahead of it
		clock_now = 64'd5000;
		for (i = 0; i < 190; i++) begin
			pick = $urandom_range(0, 39);
			if (pick == 0)
				clock_now = {$urandom, $urandom};
			else
				clock_now = clock_now + $urandom_range(0, 1500);
			stamp = clock_now;
			if (pick == 1)
				stamp = {$urandom, $urandom};
			case ($urandom_range(0, 19))
				0: dl = {$urandom, $urandom};
				1: dl = clock_now - $urandom_range(0, 500);
				2: dl = clock_now + $urandom_range(0, 3);
				3: dl = clock_now + $urandom_range(60000, 90000);
				default: dl = clock_now + $urandom_range(0, 20000);
			endcase
			add_request(($urandom_range(0, 99) < 38) ? dtq_pkg::CMD_SERVICE : dtq_pkg::CMD_ARM,
				ID_W'($urandom_range(0, 15)), dl, stamp, (i == 0 || i % 60 == 30));
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (request_backlog.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatch_count == 0 && pending_events.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
